FILE: rtl/sbsa_pkg.sv
// ----------------------------------------------------------------------------
// Segregated bitmap slot allocator package
// Sizes, pool layout, status codes and small helper functions shared by the
// allocator RTL.
// ----------------------------------------------------------------------------
package sbsa_pkg;

    localparam int SLOTS_PER_POOL = 288;
    localparam int MAP_WORD_BITS  = 24;
    localparam int NUM_CLASSES    = 3;

    localparam int MAP_WORDS  = (SLOTS_PER_POOL + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int MAP_DEPTH  = NUM_CLASSES * MAP_WORDS;
    localparam int MAP_AW     = $clog2(MAP_DEPTH);
    localparam int WORD_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W      = $clog2(MAP_WORD_BITS);
    localparam int IDX_W      = $clog2(SLOTS_PER_POOL);

    // Field widths of the stream words.
    localparam int ADDR_W       = 24;
    localparam int SIZE_W       = 24;
    localparam int STATUS_W     = 3;
    localparam int CLASS_W      = 2;
    localparam int SLOT_INDEX_W = 9;
    localparam int S_TDATA_W    = SIZE_W + ADDR_W;
    localparam int M_FIELDS_W   = STATUS_W + CLASS_W + SLOT_INDEX_W + ADDR_W;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

    // Pool layout in bytes, relative to the pool base.
    localparam int POOL_END0      = 4 * SLOTS_PER_POOL;
    localparam int POOL_END1      = 14 * SLOTS_PER_POOL;
    localparam int POOL_END2      = 30 * SLOTS_PER_POOL;
    localparam int OFF_W          = $clog2(POOL_END2);
    localparam int MAX_SLOT_BYTES = 16;

    // Division by a small constant d <= 24 is a multiply by ceil(2^S/d).
    // With S = OFF_W + 5 the quotient is exact for every offset in the pools.
    localparam int DIV_SHIFT   = OFF_W + 5;
    localparam int MUL_W       = OFF_W + 4;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int RECIP_4     = (2 ** DIV_SHIFT + 3) / 4;
    localparam int RECIP_10    = (2 ** DIV_SHIFT + 9) / 10;
    localparam int RECIP_16    = (2 ** DIV_SHIFT + 15) / 16;
    localparam int RECIP_WORD  = (2 ** DIV_SHIFT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

    localparam int LAST_WORD_BITS = SLOTS_PER_POOL - (MAP_WORDS - 1) * MAP_WORD_BITS;
    localparam logic [MAP_WORD_BITS-1:0] FULL_MASK = {MAP_WORD_BITS{1'b1}};
    localparam logic [MAP_WORD_BITS-1:0] LAST_MASK =
        FULL_MASK >> (MAP_WORD_BITS - LAST_WORD_BITS);

    localparam logic [CLASS_W-1:0] CLASS_4B  = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_10B = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_16B = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED     = 3'd0,
        ST_USE_HEAP    = 3'd1,
        ST_FREED       = 3'd2,
        ST_NOT_IN_POOL = 3'd3,
        ST_ZERO_SIZE   = 3'd4
    } status_t;

    function automatic logic [4:0] slot_bytes(input logic [CLASS_W-1:0] cls);
        logic [4:0] res;
        case (cls)
            CLASS_4B:  res = 5'd4;
            CLASS_10B: res = 5'd10;
            default:   res = 5'd16;
        endcase
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] pool_start(input logic [CLASS_W-1:0] cls);
        logic [ADDR_W-1:0] res;
        case (cls)
            CLASS_4B:  res = '0;
            CLASS_10B: res = ADDR_W'(POOL_END0);
            default:   res = ADDR_W'(POOL_END1);
        endcase
        return res;
    endfunction

    function automatic logic [MUL_W-1:0] div_recip(input logic [CLASS_W-1:0] cls);
        logic [MUL_W-1:0] res;
        case (cls)
            CLASS_4B:  res = MUL_W'(RECIP_4);
            CLASS_10B: res = MUL_W'(RECIP_10);
            default:   res = MUL_W'(RECIP_16);
        endcase
        return res;
    endfunction

    // Bitmap word address: the pools' words lie one after the other.
    function automatic logic [MAP_AW-1:0] map_addr(input logic [CLASS_W-1:0] cls,
                                                   input logic [WORD_IDX_W-1:0] word);
        logic [MAP_AW-1:0] res;
        case (cls)
            CLASS_4B:  res = MAP_AW'(word);
            CLASS_10B: res = MAP_AW'(MAP_WORDS) + MAP_AW'(word);
            default:   res = MAP_AW'(2 * MAP_WORDS) + MAP_AW'(word);
        endcase
        return res;
    endfunction

    function automatic logic [MAP_WORD_BITS-1:0] init_word(input logic is_last);
        return is_last ? LAST_MASK : FULL_MASK;
    endfunction

endpackage

FILE: rtl/segregated_bitmap_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// Segregated bitmap slot allocator
// Three fixed-size slot pools (4, 10 and 16 byte slots) tracked by free
// bitmaps; allocates the lowest free slot of the smallest fitting class and
// frees slots by address.
// ----------------------------------------------------------------------------
// An allocate passes decode, a read and a check step per bitmap word scanned (up to 12 per
// class) and, with a slot found, the address multiply. A free passes decode, the two
// divisions, the bitmap read and the write; zero size, oversize and out-of-pool requests go
// from decode to the result step. A result then waits for m_tready, and a new word is
// accepted only in the idle state, one item at a time. Reset clears the control state and
// all bitmap word valid flags, so every slot reads as free with no clearing pass.
module segregated_bitmap_slot_allocator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write channel: cfg_data is pool_base.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sbsa_pkg::ADDR_W-1:0]      cfg_data,
    // Request stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sbsa_pkg::S_TDATA_W-1:0]   s_tdata,  // request_size, free_address
    input  logic                             s_tuser,  // func
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sbsa_pkg::M_TDATA_W-1:0]   m_tdata   // status, slot_class, slot_index,
                                                       // slot_address, zero padding
);
    import sbsa_pkg::*;

    // The sequencer steps through decode, the bitmap scan and the address
    // arithmetic. The divisions and the slot address multiply share one multiplier.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ADDR_MUL,
        S_FREE_DIV,
        S_FREE_WDIV,
        S_FREE_RD,
        S_FREE_WR,
        S_RESULT
    } state_t;

    state_t                    state_reg;
    logic [ADDR_W-1:0]         pool_base_reg;
    logic                      func_reg;
    logic [SIZE_W-1:0]         size_reg;
    logic [ADDR_W-1:0]         offset_reg;
    logic [CLASS_W-1:0]        class_reg;
    logic [WORD_IDX_W-1:0]     word_reg;
    logic [IDX_W-1:0]          pos_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [BIT_W-1:0]          bit_reg;
    logic [OFF_W-1:0]          x_reg;
    logic [PROD_W-1:0]         prod_reg;
    status_t                   status_reg;

    logic                      m_tvalid_reg;
    status_t                   out_status_reg;
    logic [CLASS_W-1:0]        out_class_reg;
    logic [SLOT_INDEX_W-1:0]   out_index_reg;
    logic [ADDR_W-1:0]         out_addr_reg;

    // Free bitmap memory. A word whose valid flag is clear has never been
    // written since reset and reads as its all-free reset pattern.
    logic [MAP_WORD_BITS-1:0]  map_mem [MAP_DEPTH];
    logic [MAP_DEPTH-1:0]      map_valid_reg;
    logic [MAP_WORD_BITS-1:0]  rd_mem_reg;
    logic                      rd_valid_reg;
    logic                      rd_last_reg;

    logic [WORD_IDX_W-1:0]     div_word;
    logic [IDX_W-1:0]          div_idx;
    logic [WORD_IDX_W-1:0]     rd_word;
    logic [MAP_AW-1:0]         rd_addr;
    logic [MAP_AW-1:0]         wr_addr;
    logic [MAP_WORD_BITS-1:0]  cur_word;
    logic [BIT_W-1:0]          low_bit;
    logic [BIT_W-1:0]          sel_bit;
    logic [MAP_WORD_BITS-1:0]  bit_mask;
    logic                      wr_en;
    logic [MAP_WORD_BITS-1:0]  wr_data;
    logic [BIT_W-1:0]          bit_calc;

    logic [MUL_W-1:0]          mul_a;
    logic [MUL_W-1:0]          mul_b;
    logic [PROD_W-1:0]         mul_p;

    logic                      dec_in_pool;
    logic [CLASS_W-1:0]        dec_class;
    logic [OFF_W-1:0]          dec_x;
    logic                      has_slot;
    logic [ADDR_W-1:0]         slot_addr;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_addr_reg, out_index_reg,
                        out_class_reg, out_status_reg};

    // Quotients read from the multiplier result: slot index after the
    // division by the slot size, bitmap word after the division by the
    // word width.
    assign div_idx  = prod_reg[DIV_SHIFT +: IDX_W];
    assign div_word = prod_reg[DIV_SHIFT +: WORD_IDX_W];
    assign bit_calc = BIT_W'(idx_reg - IDX_W'(div_word) * IDX_W'(MAP_WORD_BITS));

    assign rd_word  = (state_reg == S_FREE_RD) ? div_word : word_reg;
    assign rd_addr  = map_addr(class_reg, rd_word);
    assign wr_addr  = map_addr(class_reg, word_reg);
    assign cur_word = rd_valid_reg ? rd_mem_reg : init_word(rd_last_reg);

    // Lowest set bit of the word under test.
    always_comb
    begin
        low_bit = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--)
        begin
            if (cur_word[i])
            begin
                low_bit = BIT_W'(i);
            end
        end
    end

    // An allocate clears the found bit; a free sets the decoded bit.
    assign sel_bit  = (state_reg == S_FREE_WR) ? bit_reg : low_bit;
    assign bit_mask = MAP_WORD_BITS'(1) << sel_bit;
    assign wr_en    = ((state_reg == S_SCAN_CHK) && (cur_word != '0)) ||
                      (state_reg == S_FREE_WR);
    assign wr_data  = (state_reg == S_FREE_WR) ? (cur_word | bit_mask)
                                               : (cur_word & ~bit_mask);

    // Shared multiplier: reciprocal division of the pool offset by the slot
    // size, then of the slot index by the word width, and finally the slot
    // index times the slot size for the slot address.
    always_comb
    begin
        case (state_reg)
            S_FREE_DIV:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = div_recip(class_reg);
            end
            S_FREE_WDIV:
            begin
                mul_a = MUL_W'(div_idx);
                mul_b = MUL_W'(RECIP_WORD);
            end
            default:
            begin
                mul_a = MUL_W'(idx_reg);
                mul_b = MUL_W'(slot_bytes(class_reg));
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Free address decode: which pool holds the offset, and the offset
    // within that pool.
    always_comb
    begin
        dec_in_pool = 1'b1;
        dec_class   = CLASS_4B;
        if (offset_reg < ADDR_W'(POOL_END0))
        begin
            dec_class = CLASS_4B;
        end
        else if (offset_reg < ADDR_W'(POOL_END1))
        begin
            dec_class = CLASS_10B;
        end
        else if (offset_reg < ADDR_W'(POOL_END2))
        begin
            dec_class = CLASS_16B;
        end
        else
        begin
            dec_in_pool = 1'b0;
        end
        dec_x = OFF_W'(offset_reg - pool_start(dec_class));
    end

    assign has_slot  = (status_reg == ST_GRANTED) || (status_reg == ST_FREED);
    assign slot_addr = pool_base_reg + pool_start(class_reg) + prod_reg[ADDR_W-1:0];

    // Bitmap memory port: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        rd_mem_reg   <= map_mem[rd_addr];
        rd_valid_reg <= map_valid_reg[rd_addr];
        rd_last_reg  <= (rd_word == WORD_IDX_W'(MAP_WORDS - 1));
    end

    // Sequencer, configuration register and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pool_base_reg <= '0;
            map_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                pool_base_reg <= cfg_data;
            end
            if (wr_en)
            begin
                map_valid_reg[wr_addr] <= 1'b1;
            end
            // The result step reloads the output register itself.
            if (m_tvalid_reg && m_tready && (state_reg != S_RESULT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        func_reg   <= s_tuser;
                        size_reg   <= s_tdata[SIZE_W-1:0];
                        offset_reg <= s_tdata[S_TDATA_W-1:SIZE_W] - pool_base_reg;
                        state_reg  <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    if (func_reg == FUNC_ALLOC)
                    begin
                        if (size_reg == '0)
                        begin
                            status_reg <= ST_ZERO_SIZE;
                            state_reg  <= S_RESULT;
                        end
                        else if (size_reg > SIZE_W'(MAX_SLOT_BYTES))
                        begin
                            status_reg <= ST_USE_HEAP;
                            state_reg  <= S_RESULT;
                        end
                        else
                        begin
                            if (size_reg <= SIZE_W'(4))
                            begin
                                class_reg <= CLASS_4B;
                            end
                            else if (size_reg <= SIZE_W'(10))
                            begin
                                class_reg <= CLASS_10B;
                            end
                            else
                            begin
                                class_reg <= CLASS_16B;
                            end
                            word_reg  <= '0;
                            pos_reg   <= '0;
                            state_reg <= S_SCAN_RD;
                        end
                    end
                    else if (dec_in_pool)
                    begin
                        class_reg <= dec_class;
                        x_reg     <= dec_x;
                        state_reg <= S_FREE_DIV;
                    end
                    else
                    begin
                        status_reg <= ST_NOT_IN_POOL;
                        state_reg  <= S_RESULT;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK:
                begin
                    // The word read last cycle is in cur_word. A hit is
                    // written back with its bit cleared in this cycle.
                    if (cur_word != '0)
                    begin
                        idx_reg    <= pos_reg + IDX_W'(low_bit);
                        status_reg <= ST_GRANTED;
                        state_reg  <= S_ADDR_MUL;
                    end
                    else if (word_reg != WORD_IDX_W'(MAP_WORDS - 1))
                    begin
                        word_reg  <= word_reg + WORD_IDX_W'(1);
                        pos_reg   <= pos_reg + IDX_W'(MAP_WORD_BITS);
                        state_reg <= S_SCAN_RD;
                    end
                    else if (class_reg != CLASS_16B)
                    begin
                        // Class full: fall through to the next larger class.
                        class_reg <= class_reg + CLASS_W'(1);
                        word_reg  <= '0;
                        pos_reg   <= '0;
                        state_reg <= S_SCAN_RD;
                    end
                    else
                    begin
                        status_reg <= ST_USE_HEAP;
                        state_reg  <= S_RESULT;
                    end
                end
                S_ADDR_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_RESULT;
                end
                S_FREE_DIV:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_FREE_WDIV;
                end
                S_FREE_WDIV:
                begin
                    idx_reg   <= div_idx;
                    prod_reg  <= mul_p;
                    state_reg <= S_FREE_RD;
                end
                S_FREE_RD:
                begin
                    word_reg  <= div_word;
                    bit_reg   <= bit_calc;
                    state_reg <= S_FREE_WR;
                end
                S_FREE_WR:
                begin
                    prod_reg   <= mul_p;
                    status_reg <= ST_FREED;
                    state_reg  <= S_RESULT;
                end
                S_RESULT:
                begin
                    // Wait here while an earlier result is still unread.
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        out_status_reg <= status_reg;
                        out_class_reg  <= has_slot ? class_reg : '0;
                        out_index_reg  <= has_slot ? SLOT_INDEX_W'(idx_reg) : '0;
                        out_addr_reg   <= has_slot ? slot_addr : '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A scan hit must take exactly one slot out of the bitmap word.
    a_scan_clears_one: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN_CHK) && wr_en) |->
        ($countones(wr_data) + 1 == $countones(cur_word)))
        else $error("allocation write did not clear exactly one bit");

    // A granted or freed slot lies inside its pool.
    a_index_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && ((out_status_reg == ST_GRANTED) || (out_status_reg == ST_FREED)))
        |-> (out_index_reg < SLOTS_PER_POOL))
        else $error("slot index beyond pool size");

    // Results without a slot carry all-zero slot fields.
    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (out_status_reg != ST_GRANTED) && (out_status_reg != ST_FREED))
        |-> ((out_addr_reg == '0) && (out_class_reg == '0) && (out_index_reg == '0)))
        else $error("nonzero slot fields on a result without a slot");

    // A new result only appears after the sequencer reached its result step.
    a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result word raised outside the result step");

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the segregated bitmap slot allocator
// Sends allocate and free requests on the request stream and keeps its own
// model of the three slot pools and their free bitmaps. Every result word is
// checked field by field against the model's prediction. The pool base is
// rewritten between phases, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sbsa_pkg::*;

    // Bit positions of the result fields inside m_tdata, lowest field first.
    localparam int RES_STATUS_LSB = 0;
    localparam int RES_CLASS_LSB  = RES_STATUS_LSB + STATUS_W;
    localparam int RES_INDEX_LSB  = RES_CLASS_LSB + CLASS_W;
    localparam int RES_ADDR_LSB   = RES_INDEX_LSB + SLOT_INDEX_W;

    typedef struct {
        logic              func;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
    } slot_request_t;

    typedef struct {
        status_t                 status;
        logic [CLASS_W-1:0]      cls;
        logic [SLOT_INDEX_W-1:0] index;
        logic [ADDR_W-1:0]       addr;
    } slot_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [ADDR_W-1:0]      cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;  // request_size, free_address
    logic                   s_tuser   = 1'b0; // func
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;         // status, slot_class, slot_index,
                                             // slot_address, zero padding

    segregated_bitmap_slot_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // Slot geometry of the three classes, in bytes from the pool base.
    int unsigned class_bytes [NUM_CLASSES] = '{4, 10, 16};
    int unsigned class_offset[NUM_CLASSES] = '{0, POOL_END0, POOL_END1};

    // Mirror of the allocator: the pool base and one free bitmap per class.
    // A set bit marks a free slot; bit b of word w is slot w*MAP_WORD_BITS+b.
    logic [ADDR_W-1:0]        pool_base_mirror = '0;
    logic [MAP_WORD_BITS-1:0] free_words [NUM_CLASSES][MAP_WORDS];

    slot_request_t pending_requests[$];
    slot_result_t  expected_results[$];
    slot_request_t on_bus;

    int words_queued   = 0;
    int words_accepted = 0;
    int results_seen   = 0;
    int errors         = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int n_granted      = 0;
    int n_use_heap     = 0;
    int n_freed        = 0;
    int n_not_in_pool  = 0;
    int n_zero_size    = 0;

    // Byte address of a slot under the current pool base, wrapping at 24 bits.
    function automatic logic [ADDR_W-1:0] slot_base(int unsigned c, int unsigned s);
        return ADDR_W'(pool_base_mirror + class_offset[c] + s * class_bytes[c]);
    endfunction

    // Serves one request against the mirrored bitmaps and returns the result
    // the block must produce. Allocation takes the lowest free slot of the
    // smallest class that fits and falls through to larger classes when full.
    function automatic slot_result_t serve_request(slot_request_t rq);
        slot_result_t      res;
        logic [ADDR_W-1:0] off;
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       p;
        bit                placed;
        res    = '{ST_USE_HEAP, '0, '0, '0};
        placed = 1'b0;
        if (rq.func == FUNC_ALLOC)
        begin
            if (rq.size == '0)
                res.status = ST_ZERO_SIZE;
            else
            begin
                for (int c = 0; c < NUM_CLASSES; c++)
                begin
                    if (!placed && rq.size <= class_bytes[c])
                    begin
                        for (int s = 0; s < SLOTS_PER_POOL; s++)
                        begin
                            if (!placed && free_words[c][s / MAP_WORD_BITS][s % MAP_WORD_BITS])
                            begin
                                free_words[c][s / MAP_WORD_BITS][s % MAP_WORD_BITS] = 1'b0;
                                res = '{ST_GRANTED, CLASS_W'(c), SLOT_INDEX_W'(s),
                                        slot_base(c, s)};
                                placed = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        else
        begin
            // The offset wraps, so an address just below the base is far away.
            off        = rq.addr - pool_base_mirror;
            res.status = ST_NOT_IN_POOL;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                lo = class_offset[c];
                hi = lo + SLOTS_PER_POOL * class_bytes[c];
                if (off >= lo && off < hi)
                begin
                    // A misaligned address rounds down to its slot.
                    p = (off - lo) / class_bytes[c];
                    free_words[c][p / MAP_WORD_BITS][p % MAP_WORD_BITS] = 1'b1;
                    res = '{ST_FREED, CLASS_W'(c), SLOT_INDEX_W'(p), slot_base(c, p)};
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. A word stays on the bus until the block takes it; the
    // prediction is made at the edge where the handshake completes, so the
    // mirror always sees requests in the order the block serves them.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(serve_request(on_bus));
                words_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    on_bus = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {on_bus.addr, on_bus.size};
                    s_tuser  <= on_bus.func;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Each accepted result word is compared with the oldest
    // prediction; the ready line stalls at random according to the phase.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        slot_result_t want;
        logic [STATUS_W-1:0]     got_status;
        logic [CLASS_W-1:0]      got_class;
        logic [SLOT_INDEX_W-1:0] got_index;
        logic [ADDR_W-1:0]       got_addr;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_status = m_tdata[RES_STATUS_LSB +: STATUS_W];
                got_class  = m_tdata[RES_CLASS_LSB +: CLASS_W];
                got_index  = m_tdata[RES_INDEX_LSB +: SLOT_INDEX_W];
                got_addr   = m_tdata[RES_ADDR_LSB +: ADDR_W];
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word, expected none, got status %0d "
                             , $time, got_status,
                             "class %0d index %0d address %h",
                             got_class, got_index, got_addr);
                end
                else
                begin
                    want = expected_results.pop_front();
                    case (want.status)
                        ST_GRANTED:     n_granted++;
                        ST_USE_HEAP:    n_use_heap++;
                        ST_FREED:       n_freed++;
                        ST_NOT_IN_POOL: n_not_in_pool++;
                        default:        n_zero_size++;
                    endcase
                    if (got_status !== want.status || got_class !== want.cls ||
                        got_index !== want.index || got_addr !== want.addr)
                    begin
                        errors++;
                        $display("%0t: result mismatch, expected status %0d class %0d ",
                                 $time, want.status, want.cls,
                                 "index %0d address %h, got status %0d class %0d ",
                                 want.index, want.addr, got_status, got_class,
                                 "index %0d address %h", got_index, got_addr);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    // The field that the operation ignores always carries random bits.
    task automatic queue_alloc(logic [SIZE_W-1:0] size);
        pending_requests.push_back('{FUNC_ALLOC, size, ADDR_W'($urandom)});
        words_queued++;
    endtask

    task automatic queue_free(logic [ADDR_W-1:0] addr);
        pending_requests.push_back('{FUNC_FREE, SIZE_W'($urandom), addr});
        words_queued++;
    endtask

    // A random byte anywhere inside a random slot, so frees are often
    // misaligned and may hit slots that are already free.
    task automatic queue_free_in_pool();
        int unsigned c;
        int unsigned s;
        c = $urandom_range(0, NUM_CLASSES - 1);
        s = $urandom_range(0, SLOTS_PER_POOL - 1);
        queue_free(slot_base(c, s) + ADDR_W'($urandom_range(0, class_bytes[c] - 1)));
    endtask

    // A run of allocations sized for one class: enough of them fill the
    // class and push the overflow into the larger classes or the heap.
    task automatic queue_fill(int n, int lo, int hi);
        repeat (n)
            queue_alloc(SIZE_W'($urandom_range(lo, hi)));
    endtask

    // Mostly well-formed traffic with random content, plus some noise.
    task automatic queue_mixed(int n, int lo, int hi);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                queue_alloc(SIZE_W'($urandom_range(lo, hi)));
            else if (r < 80)
                queue_free_in_pool();
            else if (r < 87)
                queue_free(ADDR_W'($urandom));
            else if (r < 94)
                queue_alloc(SIZE_W'($urandom));
            else if (r < 97)
                queue_alloc('0);
            else
                queue_alloc(SIZE_W'($urandom_range(1, MAX_SLOT_BYTES)));
        end
    endtask

    // Returns on a falling edge once every queued word has been taken and
    // every predicted result has come back. Each request yields exactly one
    // result, so the block is idle at that point.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (words_accepted != words_queued || expected_results.size() != 0);
    endtask

    // Writes the pool base; only called while the block is idle.
    task automatic write_pool_base(logic [ADDR_W-1:0] base);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= base;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid        <= 1'b0;
        pool_base_mirror = base;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        // After reset every slot of every pool is free.
        for (int c = 0; c < NUM_CLASSES; c++)
            for (int w = 0; w < MAP_WORDS; w++)
                for (int b = 0; b < MAP_WORD_BITS; b++)
                    free_words[c][w][b] = (w * MAP_WORD_BITS + b < SLOTS_PER_POOL);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with the pool base at zero.
        send_gap_pct   = 8;
        recv_stall_pct = 45;
        write_pool_base('0);
        queue_alloc('0);                              // zero size
        queue_alloc('1);                              // largest size, to the heap
        queue_alloc(SIZE_W'(MAX_SLOT_BYTES + 1));     // just too big
        queue_alloc(SIZE_W'(1));                      // smallest class, first slot
        queue_alloc(SIZE_W'(4));
        queue_alloc(SIZE_W'(5));                      // middle class
        queue_alloc(SIZE_W'(10));
        queue_alloc(SIZE_W'(11));                     // largest class
        queue_alloc(SIZE_W'(MAX_SLOT_BYTES));
        queue_alloc(SIZE_W'(24'h800000));             // top size bit alone
        queue_free('0);                               // address zero is a real slot
        queue_free('0);                               // freeing a free slot again
        queue_free(ADDR_W'(POOL_END0 + 13));          // misaligned, middle class
        queue_free(ADDR_W'(POOL_END0 - 1));           // last byte of the first pool
        queue_free(ADDR_W'(POOL_END0));               // first byte of the second pool
        queue_free(ADDR_W'(POOL_END1 - 1));
        queue_free(ADDR_W'(POOL_END1));
        queue_free(ADDR_W'(POOL_END2 - 1));           // last byte of the last pool
        queue_free(ADDR_W'(POOL_END2));               // one past the pools
        queue_free('1);                               // top of the address space
        queue_alloc(SIZE_W'(3));                      // reuses the slot freed above
        queue_alloc(SIZE_W'(7));
        wait_drained();

        // Largest base: the pools wrap around the top of the address space.
        write_pool_base('1);
        queue_fill(290, 11, MAX_SLOT_BYTES);
        queue_mixed(30, 11, MAX_SLOT_BYTES);
        wait_drained();

        // Random base; the middle class fills and spills into the largest.
        send_gap_pct   = 45;
        recv_stall_pct = 8;
        write_pool_base(ADDR_W'($urandom));
        queue_fill(295, 5, 10);
        queue_mixed(30, 5, 10);
        wait_drained();

        // Base just below the wrap point, no idling on either side.
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_pool_base(ADDR_W'(24'hFFE000));
        queue_mixed(200, 1, MAX_SLOT_BYTES);
        wait_drained();

        // Longest allocate scan is well under this.
        repeat (100) @(posedge clk);

        $display("Checked %0d results over %0d requests: %0d grants, %0d heap referrals,",
                 results_seen, words_accepted, n_granted, n_use_heap);
        $display("%0d frees, %0d frees outside the pools, %0d zero sizes; %0d errors.",
                 n_freed, n_not_in_pool, n_zero_size, errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
